[src/iqlms_pkg.sv]
package iqlms_pkg;

   localparam int GAIN_SHIFT = 16;
   localparam int TONE_GAIN  = 52429;

   localparam longint SIN_A1 = 64'sd1686629713;
   localparam longint SIN_A3 = 64'sd693598668;
   localparam longint SIN_A5 = 64'sd85569307;
   localparam longint SIN_A7 = 64'sd5026994;
   localparam longint SIN_A9 = 64'sd172272;

   localparam logic [3:0] CSR_MODE       = 4'd0;
   localparam logic [3:0] CSR_PHASE_STEP = 4'd1;
   localparam logic [3:0] CSR_ALPHA      = 4'd2;
   localparam logic [3:0] CSR_BETA       = 4'd3;

   localparam logic [1:0] SH_NONE   = 2'd0;
   localparam logic [1:0] SH_SAMPLE = 2'd1;
   localparam logic [1:0] SH_GAIN   = 2'd2;
   localparam logic [1:0] SH_COEF   = 2'd3;

   typedef struct packed {
      logic       chain;
      logic       sub;
      logic [1:0] shift;
   } iqlms_mac_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iqlms_div_stat_type;

   function automatic longint rshr(input longint v, input int n);
      if (n <= 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint sat(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // quarter-wave odd polynomial in Q30, full turn = 2^32
   function automatic longint sine_value(input longint turn, input int sw);
      longint quad;
      longint t;
      longint t2;
      longint p;
      longint s;
      quad = (turn >>> 30) & 64'sd3;
      t = turn & 64'sh3FFF_FFFF;
      if (quad[0]) t = (64'sd1 <<< 30) - t;
      t2 = rshr(t * t, 30);
      p = SIN_A9;
      p = rshr(p * t2, 30) - SIN_A7;
      p = rshr(p * t2, 30) + SIN_A5;
      p = rshr(p * t2, 30) - SIN_A3;
      p = rshr(p * t2, 30) + SIN_A1;
      s = rshr(p * t, 30);
      s = sat(rshr(s, 30 - (sw - 1)), sw);
      return quad[1] ? -s : s;
   endfunction

endpackage

[src/iqlms_sine_rom.sv]
module iqlms_sine_rom import iqlms_pkg::*; #(
   parameter int SW    = 16,
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   output logic signed [SW-1:0]       data
);

   localparam int AW = $clog2(DEPTH);

   typedef logic signed [SW-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < DEPTH; k++) begin
         r[k] = SW'(sine_value(longint'(k) <<< (32 - AW), SW));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic signed [SW-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SINE_ROM[addr];
   end

   assign data = data_ff;

endmodule

[src/iqlms_mac.sv]
module iqlms_mac import iqlms_pkg::*; #(
   parameter int OPW   = 25,
   parameter int ACCW  = 52,
   parameter int SFRAC = 15,
   parameter int CFRAC = 22
) (
   input  logic                     clock,
   input  iqlms_mac_ctrl_type       ctrl,
   input  logic signed [OPW-1:0]    op_a,
   input  logic signed [OPW-1:0]    op_b,
   input  logic signed [ACCW-1:0]   init,
   output logic signed [ACCW-1:0]   sum
);

   localparam logic signed [ACCW-1:0] HALF_S = ACCW'(1) << (SFRAC - 1);
   localparam logic signed [ACCW-1:0] HALF_G = ACCW'(1) << (GAIN_SHIFT - 1);
   localparam logic signed [ACCW-1:0] HALF_C = ACCW'(1) << (CFRAC - 1);

   logic signed [2*OPW-1:0] prod;
   logic signed [ACCW-1:0]  prod_x;
   logic signed [ACCW-1:0]  term;
   logic signed [ACCW-1:0]  base;
   logic signed [ACCW-1:0]  acc_ff;

   always_comb begin
      prod   = op_a * op_b;
      prod_x = ACCW'(prod);
      unique case (ctrl.shift)
         SH_NONE:   term = prod_x;
         SH_SAMPLE: term = (prod_x + HALF_S) >>> SFRAC;
         SH_GAIN:   term = (prod_x + HALF_G) >>> GAIN_SHIFT;
         SH_COEF:   term = (prod_x + HALF_C) >>> CFRAC;
      endcase
      base = ctrl.chain ? acc_ff : init;
      sum  = ctrl.sub ? base - term : base + term;
   end

   always_ff @(posedge clock) begin
      acc_ff <= sum;
   end

endmodule

[src/iqlms_divider.sv]
module iqlms_divider import iqlms_pkg::*; #(
   parameter int CW = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CW-1:0]         dividend,
   input  logic [2*CW-1:0]       divisor,
   output logic [CW-2:0]         quotient,
   output iqlms_div_stat_type    stat
);

   localparam int N    = 3 * CW - 4;
   localparam int DW   = 2 * CW;
   localparam int CNTW = $clog2(N + 1);

   logic            busy_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [DW:0]     rem_ff;
   logic [CW-1:0]   num_ff;
   logic [CW-1:0]   q_ff;
   logic            ovf_ff;
   logic [DW:0]     trial;
   logic            ge;

   always_comb begin
      trial = {rem_ff[DW-1:0], num_ff[CW-1]};
      ge    = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNTW'(N);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= dividend;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff && cnt_ff != '0) begin
         rem_ff <= ge ? trial - {1'b0, divisor} : trial;
         num_ff <= num_ff << 1;
         q_ff   <= {q_ff[CW-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[CW-1];
      end
   end

   assign quotient  = (ovf_ff | q_ff[CW-1]) ? '1 : q_ff[CW-2:0];
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && cnt_ff == '0;

endmodule

[src/iq_lms_tone_canceller.sv]
// Two-tap complex LMS tone canceller. Each transfer on req_ carries one IQ sample and yields
// exactly one transfer on rsp_: in identify mode a 0.8-amplitude test tone, in cancel mode the
// negated rotated predistortion term. All multiplications run on one shared multiply-round-
// accumulate unit. An item takes the two sine ROM reads, then 16 MAC steps in identify mode
// or 22 in cancel mode, then, in identify mode with a nonzero tone tap, two bit-serial
// reciprocal divisions, and last a load of the result register. The input is stalled
// while an item is in work; a finished result waits in its output register.
module iq_lms_tone_canceller import iqlms_pkg::*; #(
   parameter int SAMPLE_WIDTH     = 16,
   parameter int COEF_WIDTH       = 24,
   parameter int PHASE_WIDTH      = 24,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_q,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_im,
   input  logic                          csr_write,
   input  logic [3:0]                    csr_index,
   input  logic [23:0]                   csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COEF_WIDTH;
   localparam int PW    = PHASE_WIDTH;
   localparam int AW    = $clog2(SINE_TABLE_DEPTH);
   localparam int SFRAC = SW - 1;
   localparam int CFRAC = CW - 2;
   localparam int MAXW  = SW > CW ? SW : CW;
   localparam int OPW   = MAXW > 17 ? MAXW : 17;
   localparam int ACCW  = 2 * OPW + 2;
   localparam int DW    = 2 * CW;

   localparam int ALP = CFRAC >= SFRAC ? CFRAC - SFRAC : 0;
   localparam int ALN = CFRAC >= SFRAC ? 0 : SFRAC - CFRAC;
   localparam int OLP = SFRAC >= CFRAC ? SFRAC - CFRAC : 0;
   localparam int OLN = SFRAC >= CFRAC ? 0 : CFRAC - SFRAC;
   localparam logic signed [ACCW-1:0] RND_IN  = ACCW'((2 ** ALN) / 2);
   localparam logic signed [ACCW-1:0] RND_OUT = ACCW'((2 ** OLN) / 2);

   localparam int PSL = PW > 24 ? PW - 24 : 0;
   localparam int PSR = PW < 24 ? 24 - PW : 0;

   localparam logic signed [ACCW-1:0] CMAX = {{(ACCW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [ACCW-1:0] CMIN = ~CMAX;
   localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACCW-1:0] SMIN = ~SMAX;
   localparam logic signed [OPW-1:0]  TONE = OPW'(TONE_GAIN);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ROM_SIN = 3'd1;
   localparam logic [2:0] ST_ROM_COS = 3'd2;
   localparam logic [2:0] ST_MAC     = 3'd3;
   localparam logic [2:0] ST_DIV_RE  = 3'd4;
   localparam logic [2:0] ST_DIV_IM  = 3'd5;
   localparam logic [2:0] ST_OUT     = 3'd6;

   localparam logic [3:0] DST_NONE     = 4'd0;
   localparam logic [3:0] DST_ER       = 4'd1;
   localparam logic [3:0] DST_EI       = 4'd2;
   localparam logic [3:0] DST_GRE      = 4'd3;
   localparam logic [3:0] DST_GIM      = 4'd4;
   localparam logic [3:0] DST_T0       = 4'd5;
   localparam logic [3:0] DST_T1       = 4'd6;
   localparam logic [3:0] DST_T2       = 4'd7;
   localparam logic [3:0] DST_T3       = 4'd8;
   localparam logic [3:0] DST_MAG      = 4'd9;
   localparam logic [3:0] DST_TONE_RE  = 4'd10;
   localparam logic [3:0] DST_TONE_IM  = 4'd11;
   localparam logic [3:0] DST_CORR_RE  = 4'd12;
   localparam logic [3:0] DST_CORR_IM  = 4'd13;
   localparam logic [3:0] DST_P0       = 4'd14;
   localparam logic [3:0] DST_P1       = 4'd15;

   function automatic logic signed [CW-1:0] sat_coef(input logic signed [ACCW-1:0] v);
      if (v > CMAX) return CMAX[CW-1:0];
      if (v < CMIN) return CMIN[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] sat_samp(input logic signed [ACCW-1:0] v);
      if (v > SMAX) return SMAX[SW-1:0];
      if (v < SMIN) return SMIN[SW-1:0];
      return v[SW-1:0];
   endfunction

   // configuration
   logic          mode_ff;
   logic [23:0]   phase_step_ff;
   logic [15:0]   alpha_ff;
   logic [15:0]   beta_ff;

   // control
   logic [2:0]    state_ff;
   logic [4:0]    step_ff;
   logic          m_ff;
   logic          rsp_valid_ff;

   // state
   logic [PW-1:0]        phase_ff [2];
   logic signed [CW-1:0] ident_ff [4];
   logic signed [CW-1:0] cancel_ff [4];
   logic signed [CW-1:0] recip_ff [2];
   logic signed [CW-1:0] pcoef_ff [2];

   // working registers
   logic signed [SW-1:0] in_i_ff;
   logic signed [SW-1:0] in_q_ff;
   logic signed [SW-1:0] sn_ff;
   logic signed [SW-1:0] cs_ff;
   logic signed [CW-1:0] er_ff;
   logic signed [CW-1:0] ei_ff;
   logic signed [CW-1:0] gre_ff;
   logic signed [CW-1:0] gim_ff;
   logic [DW-1:0]        mag_ff;
   logic signed [SW-1:0] ore_ff;
   logic signed [SW-1:0] oim_ff;
   logic signed [SW-1:0] rsp_re_ff;
   logic signed [SW-1:0] rsp_im_ff;

   logic                    accept;
   logic                    last_step;
   logic                    out_load;
   logic signed [CW-1:0]    tap [4];
   logic [AW-1:0]           sin_idx;
   logic [AW-1:0]           rom_addr;
   logic signed [SW-1:0]    rom_data;
   logic [23+PSL:0]         step_wide;
   logic [PW-1:0]           step_sc;
   logic signed [ACCW-1:0]  ial_i;
   logic signed [ACCW-1:0]  ial_q;
   logic signed [ACCW-1:0]  corr_x;
   logic signed [SW-1:0]    corr_o;
   logic [CW-1:0]           abs_t2;
   logic [CW-1:0]           abs_t3;

   iqlms_mac_ctrl_type      ctrl;
   logic signed [OPW-1:0]   op_a;
   logic signed [OPW-1:0]   op_b;
   logic signed [ACCW-1:0]  init;
   logic signed [ACCW-1:0]  sum;
   logic [3:0]              dest;

   logic                    div_start;
   logic [CW-1:0]           div_a;
   logic [CW-2:0]           div_q;
   logic signed [CW-1:0]    div_qs;
   iqlms_div_stat_type      div_stat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign last_step = m_ff ? (step_ff == 5'd21) : (step_ff == 5'd15);
   assign out_load  = state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tap[k] = m_ff ? cancel_ff[k] : ident_ff[k];
      end
      sin_idx   = phase_ff[mode_ff][PW-1 -: AW];
      rom_addr  = state_ff == ST_IDLE ? sin_idx
                : phase_ff[m_ff][PW-1 -: AW] + AW'(SINE_TABLE_DEPTH / 4);
      step_wide = (24 + PSL)'(phase_step_ff) << PSL;
      step_sc   = PW'(step_wide >> PSR);
      ial_i     = ((ACCW'(in_i_ff) <<< ALP) + RND_IN) >>> ALN;
      ial_q     = ((ACCW'(in_q_ff) <<< ALP) + RND_IN) >>> ALN;
      corr_x    = -(((ACCW'(sat_coef(sum)) <<< OLP) + RND_OUT) >>> OLN);
      corr_o    = sat_samp(corr_x);
      abs_t2    = ident_ff[2][CW-1] ? CW'(-ident_ff[2]) : CW'(ident_ff[2]);
      abs_t3    = ident_ff[3][CW-1] ? CW'(-ident_ff[3]) : CW'(ident_ff[3]);
      div_qs    = CW'({1'b0, div_q});
   end

   // MAC step program
   always_comb begin
      ctrl = '0;
      op_a = '0;
      op_b = '0;
      init = '0;
      dest = DST_NONE;
      unique case (step_ff)
         5'd0: begin
            init = ial_i - ACCW'(tap[0]);
            op_a = OPW'(cs_ff); op_b = OPW'(tap[2]);
            ctrl.sub = 1'b1; ctrl.shift = SH_SAMPLE;
         end
         5'd1: begin
            op_a = OPW'(sn_ff); op_b = OPW'(tap[3]);
            ctrl.chain = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_ER;
         end
         5'd2: begin
            init = ial_q - ACCW'(tap[1]);
            op_a = OPW'(cs_ff); op_b = OPW'(tap[3]);
            ctrl.sub = 1'b1; ctrl.shift = SH_SAMPLE;
         end
         5'd3: begin
            op_a = OPW'(sn_ff); op_b = OPW'(tap[2]);
            ctrl.chain = 1'b1; ctrl.sub = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_EI;
         end
         5'd4: begin
            op_a = OPW'(er_ff); op_b = OPW'(cs_ff); ctrl.shift = SH_SAMPLE;
         end
         5'd5: begin
            op_a = OPW'(ei_ff); op_b = OPW'(sn_ff);
            ctrl.chain = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_GRE;
         end
         5'd6: begin
            op_a = OPW'(ei_ff); op_b = OPW'(cs_ff); ctrl.shift = SH_SAMPLE;
         end
         5'd7: begin
            op_a = OPW'(er_ff); op_b = OPW'(sn_ff);
            ctrl.chain = 1'b1; ctrl.sub = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_GIM;
         end
         5'd8: begin
            init = ACCW'(tap[0]); op_a = OPW'({1'b0, alpha_ff}); op_b = OPW'(er_ff);
            ctrl.shift = SH_GAIN; dest = DST_T0;
         end
         5'd9: begin
            init = ACCW'(tap[1]); op_a = OPW'({1'b0, alpha_ff}); op_b = OPW'(ei_ff);
            ctrl.shift = SH_GAIN; dest = DST_T1;
         end
         5'd10: begin
            init = ACCW'(tap[2]); op_a = OPW'({1'b0, alpha_ff}); op_b = OPW'(gre_ff);
            ctrl.shift = SH_GAIN; dest = DST_T2;
         end
         5'd11: begin
            init = ACCW'(tap[3]); op_a = OPW'({1'b0, alpha_ff}); op_b = OPW'(gim_ff);
            ctrl.shift = SH_GAIN; dest = DST_T3;
         end
         5'd12: begin
            if (m_ff) begin
               op_a = OPW'(cs_ff); op_b = OPW'(pcoef_ff[0]); ctrl.shift = SH_SAMPLE;
            end else begin
               op_a = OPW'(tap[2]); op_b = OPW'(tap[2]); ctrl.shift = SH_NONE;
            end
         end
         5'd13: begin
            ctrl.chain = 1'b1;
            if (m_ff) begin
               op_a = OPW'(sn_ff); op_b = OPW'(pcoef_ff[1]);
               ctrl.sub = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_CORR_RE;
            end else begin
               op_a = OPW'(tap[3]); op_b = OPW'(tap[3]); ctrl.shift = SH_NONE; dest = DST_MAG;
            end
         end
         5'd14: begin
            if (m_ff) begin
               op_a = OPW'(cs_ff); op_b = OPW'(pcoef_ff[1]); ctrl.shift = SH_SAMPLE;
            end else begin
               op_a = TONE; op_b = OPW'(cs_ff); ctrl.shift = SH_GAIN; dest = DST_TONE_RE;
            end
         end
         5'd15: begin
            if (m_ff) begin
               op_a = OPW'(sn_ff); op_b = OPW'(pcoef_ff[0]);
               ctrl.chain = 1'b1; ctrl.shift = SH_SAMPLE; dest = DST_CORR_IM;
            end else begin
               op_a = TONE; op_b = OPW'(sn_ff); ctrl.shift = SH_GAIN; dest = DST_TONE_IM;
            end
         end
         5'd16: begin
            op_a = OPW'(recip_ff[0]); op_b = OPW'(tap[2]); ctrl.shift = SH_COEF;
         end
         5'd17: begin
            op_a = OPW'(recip_ff[1]); op_b = OPW'(tap[3]);
            ctrl.chain = 1'b1; ctrl.sub = 1'b1; ctrl.shift = SH_COEF; dest = DST_GRE;
         end
         5'd18: begin
            op_a = OPW'(recip_ff[0]); op_b = OPW'(tap[3]); ctrl.shift = SH_COEF;
         end
         5'd19: begin
            op_a = OPW'(recip_ff[1]); op_b = OPW'(tap[2]);
            ctrl.chain = 1'b1; ctrl.shift = SH_COEF; dest = DST_GIM;
         end
         5'd20: begin
            init = ACCW'(pcoef_ff[0]); op_a = OPW'({1'b0, beta_ff}); op_b = OPW'(gre_ff);
            ctrl.shift = SH_GAIN; dest = DST_P0;
         end
         5'd21: begin
            init = ACCW'(pcoef_ff[1]); op_a = OPW'({1'b0, beta_ff}); op_b = OPW'(gim_ff);
            ctrl.shift = SH_GAIN; dest = DST_P1;
         end
         default: begin
            dest = DST_NONE;
         end
      endcase
   end

   assign div_start = (state_ff == ST_MAC && last_step && !m_ff && mag_ff != '0)
                   || (state_ff == ST_DIV_RE && div_stat.done);
   assign div_a     = state_ff == ST_MAC ? abs_t2 : abs_t3;

   iqlms_sine_rom #(.SW(SW), .DEPTH(SINE_TABLE_DEPTH)) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   iqlms_mac #(.OPW(OPW), .ACCW(ACCW), .SFRAC(SFRAC), .CFRAC(CFRAC)) u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .init  (init),
      .sum   (sum)
   );

   iqlms_divider #(.CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (mag_ff),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         phase_step_ff <= '0;
         alpha_ff      <= '0;
         beta_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff       <= csr_wdata[0];
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_ALPHA:      alpha_ff      <= csr_wdata[15:0];
            CSR_BETA:       beta_ff       <= csr_wdata[15:0];
            default:        mode_ff       <= mode_ff;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         m_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_ROM_SIN;
                  m_ff     <= mode_ff;
               end
            end
            ST_ROM_SIN: state_ff <= ST_ROM_COS;
            ST_ROM_COS: begin
               state_ff <= ST_MAC;
               step_ff  <= '0;
            end
            ST_MAC: begin
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= div_start ? ST_DIV_RE : ST_OUT;
               end
            end
            ST_DIV_RE: begin
               if (div_stat.done) state_ff <= ST_DIV_IM;
            end
            ST_DIV_IM: begin
               if (div_stat.done) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            phase_ff[k] <= '0;
            recip_ff[k] <= '0;
            pcoef_ff[k] <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            ident_ff[k]  <= '0;
            cancel_ff[k] <= '0;
         end
      end else begin
         if (state_ff == ST_MAC) begin
            priority case (dest)
               DST_T0, DST_T1, DST_T2, DST_T3: begin
                  if (m_ff) cancel_ff[2'(dest - DST_T0)] <= sat_coef(sum);
                  else      ident_ff[2'(dest - DST_T0)]  <= sat_coef(sum);
               end
               DST_P0:  pcoef_ff[0] <= sat_coef(sum);
               DST_P1:  pcoef_ff[1] <= sat_coef(sum);
               default: pcoef_ff[0] <= pcoef_ff[0];
            endcase
            if (last_step) begin
               phase_ff[m_ff] <= phase_ff[m_ff] + step_sc;
               if (!m_ff && mag_ff == '0) begin
                  recip_ff[0] <= '0;
                  recip_ff[1] <= '0;
               end
            end
         end
         if (state_ff == ST_DIV_RE && div_stat.done) begin
            recip_ff[0] <= ident_ff[2][CW-1] ? -div_qs : div_qs;
         end
         if (state_ff == ST_DIV_IM && div_stat.done) begin
            recip_ff[1] <= (ident_ff[3] > 0) ? -div_qs : div_qs;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_i_ff <= req_in_i;
         in_q_ff <= req_in_q;
      end
      if (state_ff == ST_ROM_SIN) sn_ff <= rom_data;
      if (state_ff == ST_ROM_COS) cs_ff <= rom_data;
      if (state_ff == ST_MAC) begin
         priority case (dest)
            DST_ER:      er_ff  <= sat_coef(sum);
            DST_EI:      ei_ff  <= sat_coef(sum);
            DST_GRE:     gre_ff <= sat_coef(sum);
            DST_GIM:     gim_ff <= sat_coef(sum);
            DST_MAG:     mag_ff <= sum[DW-1:0];
            DST_TONE_RE: ore_ff <= sat_samp(sum);
            DST_TONE_IM: oim_ff <= sat_samp(sum);
            DST_CORR_RE: ore_ff <= corr_o;
            DST_CORR_IM: oim_ff <= corr_o;
            default:     er_ff  <= er_ff;
         endcase
      end
      if (out_load) begin
         rsp_re_ff <= ore_ff;
         rsp_im_ff <= oim_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = rsp_re_ff;
   assign rsp_out_im = rsp_im_ff;

   a_accept_starts_rom: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ROM_SIN)
      else $error("accepted transfer did not start the ROM read");

   a_div_only_in_div_states: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV_RE || state_ff == ST_DIV_IM))
      else $error("divider busy outside the reciprocal states");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result presented without finishing an item");

endmodule

[test/iq_lms_tone_canceller_tb.sv]
`timescale 1ns / 100ps

module iq_lms_tone_canceller_tb import iqlms_pkg::*;;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          SETTLE      = 300;
   localparam logic [3:0]  CSR_SPARE   = 4'd15;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } iq_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_in_i = '0;
   logic signed [15:0] req_in_q = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_re;
   logic signed [15:0] rsp_out_im;
   logic               csr_write = 1'b0;
   logic [3:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;

   // shadow registers and state
   logic        mode_r;
   logic [23:0] step_r;
   longint      alpha_r, beta_r;
   logic [23:0] phase[2];
   longint      taps[2][4];
   longint      recip[2];
   longint      pcoef[2];

   iq_type      tone_fifo[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          cycles = 0;
   bit          tx_idle_en = 1'b1;
   bit          rx_idle_en = 1'b1;
   int          hold_req = 0;

   iq_lms_tone_canceller i_dut (.*);

   always #2 clock = ~clock;

   function automatic longint rnd_shift(input longint v, input int n);
      if (n <= 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint wave_sample(input logic [31:0] turn);
      logic [1:0] quad;
      longint     t, t2, p, s;
      quad = turn[31:30];
      t = longint'(turn[29:0]);
      if (quad[0]) t = (64'sd1 <<< 30) - t;
      t2 = rnd_shift(t * t, 30);
      p = 64'sd172272;
      p = rnd_shift(p * t2, 30) - 64'sd5026994;
      p = rnd_shift(p * t2, 30) + 64'sd85569307;
      p = rnd_shift(p * t2, 30) - 64'sd693598668;
      p = rnd_shift(p * t2, 30) + 64'sd1686629713;
      s = rnd_shift(p * t, 30);
      s = clamp(rnd_shift(s, 15), 16);
      return quad[1] ? -s : s;
   endfunction

   function automatic longint recip_magnitude(input longint unsigned a, input longint unsigned d);
      longint unsigned lim, q, r;
      lim = (64'd1 << 23) - 1;
      q = a / d;
      r = a % d;
      if (q > lim) return longint'(lim);
      for (int k = 0; k < 44; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
         if (q > lim) return longint'(lim);
      end
      return longint'(q);
   endfunction

   function automatic longint tap_update(input longint x, input longint mu, input longint g);
      return clamp(x + rnd_shift(mu * g, 16), 24);
   endfunction

   task automatic canceller_step(input logic signed [15:0] si, input logic signed [15:0] sq,
                                 output iq_type res);
      int              m;
      logic [31:0]     turn;
      longint          sn, cs, yr, yi, er, ei, g1r, g1i, rr, ri, ore, oim, tr, ti;
      longint unsigned ur, ui, mag;
      m = int'(mode_r);
      turn = {8'd0, phase[m][23:14]} << 22;
      sn = wave_sample(turn);
      cs = wave_sample(turn + 32'h4000_0000);
      rr = 0;
      ri = 0;
      yr = taps[m][0] + rnd_shift(cs * taps[m][2], 15) - rnd_shift(sn * taps[m][3], 15);
      yi = taps[m][1] + rnd_shift(cs * taps[m][3], 15) + rnd_shift(sn * taps[m][2], 15);
      if (m == 1) begin
         rr = clamp(rnd_shift(cs * pcoef[0], 15) - rnd_shift(sn * pcoef[1], 15), 24);
         ri = clamp(rnd_shift(cs * pcoef[1], 15) + rnd_shift(sn * pcoef[0], 15), 24);
      end
      er = clamp(longint'(si) * 128 - yr, 24);
      ei = clamp(longint'(sq) * 128 - yi, 24);
      g1r = clamp(rnd_shift(er * cs, 15) + rnd_shift(ei * sn, 15), 24);
      g1i = clamp(rnd_shift(ei * cs, 15) - rnd_shift(er * sn, 15), 24);
      taps[m][0] = tap_update(taps[m][0], alpha_r, er);
      taps[m][1] = tap_update(taps[m][1], alpha_r, ei);
      taps[m][2] = tap_update(taps[m][2], alpha_r, g1r);
      taps[m][3] = tap_update(taps[m][3], alpha_r, g1i);
      if (m == 0) begin
         ur = taps[0][2] < 0 ? -taps[0][2] : taps[0][2];
         ui = taps[0][3] < 0 ? -taps[0][3] : taps[0][3];
         mag = ur * ur + ui * ui;
         ore = clamp(rnd_shift(64'sd52429 * cs, 16), 16);
         oim = clamp(rnd_shift(64'sd52429 * sn, 16), 16);
         if (mag == 0) begin
            recip[0] = 0;
            recip[1] = 0;
         end else begin
            recip[0] = recip_magnitude(ur, mag);
            recip[1] = recip_magnitude(ui, mag);
            if (taps[0][2] < 0) recip[0] = -recip[0];
            if (taps[0][3] > 0) recip[1] = -recip[1];
         end
      end else begin
         tr = clamp(rnd_shift(recip[0] * taps[1][2], 22) - rnd_shift(recip[1] * taps[1][3], 22),
                    24);
         ti = clamp(rnd_shift(recip[0] * taps[1][3], 22) + rnd_shift(recip[1] * taps[1][2], 22),
                    24);
         pcoef[0] = tap_update(pcoef[0], beta_r, tr);
         pcoef[1] = tap_update(pcoef[1], beta_r, ti);
         ore = clamp(-rnd_shift(rr, 7), 16);
         oim = clamp(-rnd_shift(ri, 7), 16);
      end
      phase[m] = phase[m] + step_r;
      res.re = ore[15:0];
      res.im = oim[15:0];
   endtask

   // sender: called and returns at a falling edge
   task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
      iq_type res;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_i = si;
      req_in_q = sq;
      do @(posedge clock); while (req_stall);
      canceller_step(si, sq, res);
      tone_fifo.push_back(res);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (tone_fifo.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_set(input logic [3:0] idx, input logic [23:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_MODE:       mode_r = val[0];
         CSR_PHASE_STEP: step_r = val;
         CSR_ALPHA:      alpha_r = longint'(val[15:0]);
         CSR_BETA:       beta_r = longint'(val[15:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input logic m, input logic [23:0] st, input logic [15:0] a,
                            input logic [15:0] b);
      drain();
      csr_set(CSR_MODE, {23'd0, m});
      csr_set(CSR_PHASE_STEP, st);
      csr_set(CSR_ALPHA, {8'd0, a});
      csr_set(CSR_BETA, {8'd0, b});
   endtask

   task automatic test_identify_directed;
      // zero tone tap with no adaptation: reciprocal stays zero
      configure(1'b0, 24'h040000, 16'd0, 16'd0);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sd0, 16'sd0);
      configure(1'b0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sd1, -16'sd1);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7FFF, 16'sd0);
      // ignored register index
      drain();
      csr_set(CSR_SPARE, 24'hFFFFFF);
      send_sample(16'sh5555, 16'shAAAA);
   endtask

   task automatic test_cancel_directed;
      configure(1'b1, 24'h001000, 16'hFFFF, 16'hFFFF);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7FFF, 16'sh7FFF);
      configure(1'b1, 24'd0, 16'd1, 16'd1);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh1234, 16'shEDCB);
      // back to identify: its state is kept
      configure(1'b0, 24'h800000, 16'h8000, 16'd0);
      send_sample(16'sh4000, 16'shC000);
      send_sample(16'sh7FFF, 16'sh7FFF);
   endtask

   task automatic test_random_phases;
      logic [23:0] st;
      logic [15:0] a, b;
      for (int ph = 0; ph < 12; ph++) begin
         st = (ph % 4 == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 24'hFFFFFF));
         a = (ph % 3 == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'h3FFF));
         b = (ph % 5 == 1) ? 16'd0 : 16'($urandom_range(0, 16'hFFFF));
         configure(ph[0], st, a, b);
         repeat (30) begin
            if ($urandom_range(0, 2) == 0)
               send_sample(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
            else
               send_sample($signed(16'($urandom_range(0, 8191))) - 16'sd4096,
                           $signed(16'($urandom_range(0, 8191))) - 16'sd4096);
         end
      end
   endtask

   task automatic test_backpressure;
      configure(1'b1, 24'h012345, 16'h2000, 16'h1000);
      hold_req++;
      repeat (20)
         send_sample(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
   endtask

   task automatic test_streaming;
      configure(1'b0, 24'h0ABCDE, 16'h4000, 16'h0);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      repeat (50)
         send_sample(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
      configure(1'b1, 24'h0ABCDE, 16'h4000, 16'hFFFF);
      repeat (50)
         send_sample(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
   endtask

   // result side stall: random bursts plus a long hold-off on request
   always @(negedge clock) begin : rsp_stall_gen
      int burst;
      int hold_left;
      int hold_seen;
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rx_idle_en) begin
         rsp_stall <= 1'b0;
      end else if (burst > 0) begin
         burst--;
      end else begin
         burst = $urandom_range(1, 18);
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      iq_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tone_fifo.size() == 0) begin
            $error("unexpected transfer re=%0d im=%0d", rsp_out_re, rsp_out_im);
            errors++;
         end else begin
            want = tone_fifo.pop_front();
            n_checked++;
            if (rsp_out_re !== want.re) begin
               $error("out_re expected %0d actual %0d", want.re, rsp_out_re);
               errors++;
            end
            if (rsp_out_im !== want.im) begin
               $error("out_im expected %0d actual %0d", want.im, rsp_out_im);
               errors++;
            end
         end
      end
   end

   initial begin
      mode_r = 0;
      step_r = 0;
      alpha_r = 0;
      beta_r = 0;
      phase = '{default: '0};
      taps = '{default: '{default: 0}};
      recip = '{default: 0};
      pcoef = '{default: 0};
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_identify_directed();
      test_cancel_directed();
      test_random_phases();
      test_backpressure();
      test_streaming();
      drain();
      if (tone_fifo.size() != 0) errors++;
      $display("Sent %0d samples, checked %0d results over identify and cancel modes,",
               n_sent, n_checked);
      $display("phase step, step size extremes, long result hold-off and full-rate streaming.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
